// File: hdl/ibu_pkg.sv
`timescale 1ns / 1ps

package ibu_pkg;

  localparam int W = 32;
  localparam int LANES = 4;

  typedef logic signed [W-1:0] word_t;
  typedef logic [LANES-1:0][W-1:0] lanes_t;

  typedef enum logic [3:0] {
    ACT_ADD  = 4'd0,
    ACT_SUB  = 4'd1,
    ACT_MUL  = 4'd2,
    ACT_DIV  = 4'd3,
    ACT_MIN  = 4'd4,
    ACT_MAX  = 4'd5,
    ACT_REM  = 4'd6,
    ACT_NEG  = 4'd7,
    ACT_ABS  = 4'd8,
    ACT_CONV = 4'd9,
    ACT_TRIG = 4'd10
  } action_t;

  // Sideband that travels alongside the divider lanes.
  typedef struct packed {
    logic             ok;
    logic             use_lanes;
    logic [LANES-1:0] neg;
    word_t            lo;
    word_t            hi;
  } side_t;

endpackage

// File: hdl/interval_bounds_unit.sv
`timescale 1ns / 1ps

// Interval bounds unit: each beat carries an operation and the signed bounds of
// its operands, and yields one beat with the bounds of the result, or res_known
// low with zero bounds. One beat is accepted every cycle while the output is not
// stalled, and results leave in order, after an input register, one stage of
// multiply and the other non-divide operations, 32 stages of a restoring divider
// that produces one quotient bit per stage (products ride through the same
// lanes), and an output register after the four-corner minimum and maximum. The
// whole pipeline holds still while a result waits at the output.

module interval_bounds_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [3:0]            action,
  input  logic                  lhs_known,
  input  logic signed [31:0]    lhs_min,
  input  logic signed [31:0]    lhs_max,
  input  logic                  rhs_known,
  input  logic signed [31:0]    rhs_min,
  input  logic signed [31:0]    rhs_max,
  input  logic [6:0]            target_bits,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  res_known,
  output logic signed [31:0]    res_min,
  output logic signed [31:0]    res_max
);

  logic            adv;
  logic            lane_valid, quo_valid;
  ibu_pkg::side_t  side, quo_side;
  ibu_pkg::lanes_t dvd, dvs, quo;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  ibu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .in_valid    (in_valid),
    .action      (action),
    .lhs_known   (lhs_known),
    .lhs_min     (lhs_min),
    .lhs_max     (lhs_max),
    .rhs_known   (rhs_known),
    .rhs_min     (rhs_min),
    .rhs_max     (rhs_max),
    .target_bits (target_bits),
    .lane_valid  (lane_valid),
    .side        (side),
    .dvd         (dvd),
    .dvs         (dvs)
  );

  ibu_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (lane_valid),
    .in_side   (side),
    .dvd       (dvd),
    .dvs       (dvs),
    .quo_valid (quo_valid),
    .quo_side  (quo_side),
    .quo       (quo)
  );

  ibu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .quo_valid (quo_valid),
    .quo_side  (quo_side),
    .quo       (quo),
    .out_valid (out_valid),
    .res_known (res_known),
    .res_min   (res_min),
    .res_max   (res_max)
  );

endmodule

// File: hdl/ibu_front.sv
`timescale 1ns / 1ps

module ibu_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                adv,
  input  logic                in_valid,
  input  logic [3:0]          action,
  input  logic                lhs_known,
  input  ibu_pkg::word_t      lhs_min,
  input  ibu_pkg::word_t      lhs_max,
  input  logic                rhs_known,
  input  ibu_pkg::word_t      rhs_min,
  input  ibu_pkg::word_t      rhs_max,
  input  logic [6:0]          target_bits,
  output logic                lane_valid,
  output ibu_pkg::side_t      side,
  output ibu_pkg::lanes_t     dvd,
  output ibu_pkg::lanes_t     dvs
);

  logic           s0_valid;
  logic [3:0]     s0_action;
  logic           s0_lk;
  logic           s0_rk;
  ibu_pkg::word_t a0, a1, b0, b1;
  logic [6:0]     s0_tb;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_action <= action;
      s0_lk     <= lhs_known;
      s0_rk     <= rhs_known;
      a0        <= lhs_min;
      a1        <= lhs_max;
      b0        <= rhs_min;
      b1        <= rhs_max;
      s0_tb     <= target_bits;
    end
  end

  logic signed [2*ibu_pkg::W-1:0] p1, p2, p3, p4;
  ibu_pkg::word_t mr, nr, ax, ay, pw, omax, omin;
  logic [6:0]     tb_m1;
  logic           both, div_ok, is_mul, is_div;
  ibu_pkg::side_t side_next;
  ibu_pkg::lanes_t mag, prod, dvd_next, dvs_next;

  assign both = s0_lk && s0_rk;
  assign p1 = a0 * b0;
  assign p2 = a0 * b1;
  assign p3 = a1 * b0;
  assign p4 = a1 * b1;
  assign prod = {p4[ibu_pkg::W-1:0], p3[ibu_pkg::W-1:0],
                 p2[ibu_pkg::W-1:0], p1[ibu_pkg::W-1:0]};

  assign mag[0] = a0[ibu_pkg::W-1] ? -a0 : a0;
  assign mag[1] = a1[ibu_pkg::W-1] ? -a1 : a1;
  assign mag[2] = b0[ibu_pkg::W-1] ? -b0 : b0;
  assign mag[3] = b1[ibu_pkg::W-1] ? -b1 : b1;

  assign div_ok = both && !(b0 <= 0 && b1 >= 0) && (b0 != 0) && (b1 != 0);
  assign is_mul = (ibu_pkg::action_t'(s0_action) == ibu_pkg::ACT_MUL);
  assign is_div = (ibu_pkg::action_t'(s0_action) == ibu_pkg::ACT_DIV);

  assign mr    = b0 - ibu_pkg::word_t'(1);
  assign nr    = -mr;
  assign ax    = (a1 < 0) ? -a1 : a1;
  assign ay    = (a0 < 0) ? -a0 : a0;
  assign tb_m1 = s0_tb - 7'd1;
  assign pw    = ibu_pkg::word_t'(1) << tb_m1[4:0];
  assign omax  = pw - ibu_pkg::word_t'(1);
  assign omin  = -pw;

  // A multiply goes down the divider lanes with a divisor of one, so the
  // corner selection at the far end serves both operations.
  always_comb begin
    dvd_next = is_mul ? prod : {mag[1], mag[1], mag[0], mag[0]};
    dvs_next = is_mul ? {ibu_pkg::LANES{ibu_pkg::W'(1)}}
                      : {mag[3], mag[2], mag[3], mag[2]};
    side_next.neg = is_mul ? '0 :
                    {a1[ibu_pkg::W-1] ^ b1[ibu_pkg::W-1], a1[ibu_pkg::W-1] ^ b0[ibu_pkg::W-1],
                     a0[ibu_pkg::W-1] ^ b1[ibu_pkg::W-1], a0[ibu_pkg::W-1] ^ b0[ibu_pkg::W-1]};
    side_next.ok        = 1'b0;
    side_next.use_lanes = is_mul || is_div;
    side_next.lo        = '0;
    side_next.hi        = '0;
    case (ibu_pkg::action_t'(s0_action))
      ibu_pkg::ACT_ADD: begin
        side_next.ok = both;
        side_next.lo = a0 + b0;
        side_next.hi = a1 + b1;
      end
      ibu_pkg::ACT_SUB: begin
        side_next.ok = both;
        side_next.lo = a0 - b1;
        side_next.hi = a1 - b0;
      end
      ibu_pkg::ACT_MUL: begin
        side_next.ok = both;
      end
      ibu_pkg::ACT_DIV: begin
        side_next.ok = div_ok;
      end
      ibu_pkg::ACT_MIN: begin
        side_next.ok = both;
        side_next.lo = (a0 < b0) ? a0 : b0;
        side_next.hi = (a1 < b1) ? a1 : b1;
      end
      ibu_pkg::ACT_MAX: begin
        side_next.ok = both;
        side_next.lo = (b0 < a0) ? a0 : b0;
        side_next.hi = (b1 < a1) ? a1 : b1;
      end
      ibu_pkg::ACT_REM: begin
        side_next.ok = both && (b0 == b1) && (b0 > 0);
        if (a0 >= 0) begin
          side_next.lo = '0;
          side_next.hi = (a1 < mr) ? a1 : mr;
        end else if (a1 <= 0) begin
          side_next.lo = (nr < a0) ? a0 : nr;
          side_next.hi = '0;
        end else begin
          side_next.lo = (nr < a0) ? a0 : nr;
          side_next.hi = (a1 < mr) ? a1 : mr;
        end
      end
      ibu_pkg::ACT_NEG: begin
        side_next.ok = s0_lk;
        side_next.lo = -a1;
        side_next.hi = -a0;
      end
      ibu_pkg::ACT_ABS: begin
        side_next.ok = s0_lk;
        if (a0 >= 0) begin
          side_next.lo = a0;
          side_next.hi = a1;
        end else if (a1 <= 0) begin
          side_next.lo = -a1;
          side_next.hi = -a0;
        end else begin
          side_next.lo = '0;
          side_next.hi = (ay < ax) ? ax : ay;
        end
      end
      ibu_pkg::ACT_CONV: begin
        side_next.lo = a0;
        side_next.hi = a1;
        if (s0_tb >= 7'(ibu_pkg::W)) begin
          side_next.ok = s0_lk;
        end else begin
          side_next.ok = s0_lk && (s0_tb != 7'd0) && (a0 >= omin) && (a1 <= omax);
        end
      end
      ibu_pkg::ACT_TRIG: begin
        side_next.ok = 1'b1;
        side_next.lo = -ibu_pkg::word_t'(1);
        side_next.hi = ibu_pkg::word_t'(1);
      end
      default: begin
        side_next.ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid <= 1'b0;
    end else if (adv) begin
      lane_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      side <= side_next;
      dvd  <= dvd_next;
      dvs  <= dvs_next;
    end
  end

endmodule

// File: hdl/ibu_div_pipe.sv
`timescale 1ns / 1ps

module ibu_div_pipe (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  ibu_pkg::side_t  in_side,
  input  ibu_pkg::lanes_t dvd,
  input  ibu_pkg::lanes_t dvs,
  output logic            quo_valid,
  output ibu_pkg::side_t  quo_side,
  output ibu_pkg::lanes_t quo
);

  localparam int W = ibu_pkg::W;
  localparam int L = ibu_pkg::LANES;

  logic [W:0]      st_valid;
  ibu_pkg::side_t  st_side [0:W];
  ibu_pkg::lanes_t st_r    [0:W];
  ibu_pkg::lanes_t st_n    [0:W];
  ibu_pkg::lanes_t st_d    [0:W];
  ibu_pkg::lanes_t st_q    [0:W];

  assign st_valid[0] = in_valid;
  assign st_side[0]  = in_side;
  assign st_r[0]     = '0;
  assign st_n[0]     = dvd;
  assign st_d[0]     = dvs;
  assign st_q[0]     = '0;

  // Restoring division, one quotient bit per stage, dividend bits taken from the top.
  for (genvar k = 0; k < W; k++) begin : g_stage
    ibu_pkg::lanes_t r_next, q_next;

    always_comb begin
      logic [W:0] part;
      logic [W:0] diff;
      for (int l = 0; l < L; l++) begin
        part = {st_r[k][l], st_n[k][l][W-1]};
        diff = part - {1'b0, st_d[k][l]};
        if (part >= {1'b0, st_d[k][l]}) begin
          r_next[l] = diff[W-1:0];
          q_next[l] = {st_q[k][l][W-2:0], 1'b1};
        end else begin
          r_next[l] = part[W-1:0];
          q_next[l] = {st_q[k][l][W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k+1] <= 1'b0;
      end else if (adv) begin
        st_valid[k+1] <= st_valid[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_side[k+1] <= st_side[k];
        st_r[k+1]    <= r_next;
        st_n[k+1]    <= st_n[k] << 1;
        st_d[k+1]    <= st_d[k];
        st_q[k+1]    <= q_next;
      end
    end
  end

  assign quo_valid = st_valid[W];
  assign quo_side  = st_side[W];
  assign quo       = st_q[W];

endmodule

// File: hdl/ibu_back.sv
`timescale 1ns / 1ps

module ibu_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            quo_valid,
  input  ibu_pkg::side_t  quo_side,
  input  ibu_pkg::lanes_t quo,
  output logic            out_valid,
  output logic            res_known,
  output ibu_pkg::word_t  res_min,
  output ibu_pkg::word_t  res_max
);

  ibu_pkg::word_t c [0:ibu_pkg::LANES-1];
  ibu_pkg::word_t lo01, lo23, hi01, hi23, lo_next, hi_next;

  for (genvar l = 0; l < ibu_pkg::LANES; l++) begin : g_sign
    assign c[l] = quo_side.neg[l] ? -ibu_pkg::word_t'(quo[l]) : ibu_pkg::word_t'(quo[l]);
  end

  assign lo01 = (c[0] < c[1]) ? c[0] : c[1];
  assign lo23 = (c[2] < c[3]) ? c[2] : c[3];
  assign hi01 = (c[1] < c[0]) ? c[0] : c[1];
  assign hi23 = (c[3] < c[2]) ? c[2] : c[3];

  always_comb begin
    if (!quo_side.ok) begin
      lo_next = '0;
      hi_next = '0;
    end else if (quo_side.use_lanes) begin
      lo_next = (lo01 < lo23) ? lo01 : lo23;
      hi_next = (hi23 < hi01) ? hi01 : hi23;
    end else begin
      lo_next = quo_side.lo;
      hi_next = quo_side.hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= quo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_known <= quo_side.ok;
      res_min   <= lo_next;
      res_max   <= hi_next;
    end
  end

endmodule

// File: tb/sv/interval_bounds_unit_tb.sv
`timescale 1ns / 1ps

module interval_bounds_unit_tb;

  typedef struct packed {
    logic [3:0]         act;
    logic               lk;
    logic signed [31:0] a0;
    logic signed [31:0] a1;
    logic               rk;
    logic signed [31:0] b0;
    logic signed [31:0] b1;
    logic [6:0]         tb;
  } op_item_t;

  typedef struct packed {
    logic               known;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } bounds_t;

  localparam int LATENCY = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] action = '0;
  logic lhs_known = 1'b0;
  logic signed [31:0] lhs_min = '0, lhs_max = '0;
  logic rhs_known = 1'b0;
  logic signed [31:0] rhs_min = '0, rhs_max = '0;
  logic [6:0] target_bits = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic res_known;
  logic signed [31:0] res_min, res_max;

  op_item_t pending_ops[$];
  bounds_t  expected_bounds[$];
  int  errors = 0;
  int  send_idle_pct = 0, recv_idle_pct = 0;
  int  hold_recv = 0;
  bit  send_pause = 1'b0;

  interval_bounds_unit dut (.*);

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic logic signed [31:0] sdiv(logic signed [31:0] a, logic signed [31:0] b);
    // Truncation toward zero; the most negative value over -1 wraps.
    if (a == 32'sh8000_0000 && b == -32'sd1) return a;
    return a / b;
  endfunction

  function automatic logic signed [31:0] smin(logic signed [31:0] a, logic signed [31:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [31:0] smax(logic signed [31:0] a, logic signed [31:0] b);
    return (b < a) ? a : b;
  endfunction

  function automatic bounds_t predict_bounds(op_item_t it);
    bounds_t r;
    logic signed [31:0] c[4];
    logic signed [31:0] mr, omax, omin;
    logic both;
    r = '0;
    both = it.lk && it.rk;
    case (it.act)
      ibu_pkg::ACT_ADD: if (both) begin
        r = {1'b1, it.a0 + it.b0, it.a1 + it.b1};
      end
      ibu_pkg::ACT_SUB: if (both) begin
        r = {1'b1, it.a0 - it.b1, it.a1 - it.b0};
      end
      ibu_pkg::ACT_MUL, ibu_pkg::ACT_DIV: begin
        if (both && (it.act == ibu_pkg::ACT_MUL ||
            (!(it.b0 <= 0 && it.b1 >= 0) && it.b0 != 0 && it.b1 != 0))) begin
          if (it.act == ibu_pkg::ACT_MUL) begin
            c[0] = it.a0 * it.b0; c[1] = it.a0 * it.b1;
            c[2] = it.a1 * it.b0; c[3] = it.a1 * it.b1;
          end else begin
            c[0] = sdiv(it.a0, it.b0); c[1] = sdiv(it.a0, it.b1);
            c[2] = sdiv(it.a1, it.b0); c[3] = sdiv(it.a1, it.b1);
          end
          r.known = 1'b1;
          r.lo = smin(smin(c[0], c[1]), smin(c[2], c[3]));
          r.hi = smax(smax(c[0], c[1]), smax(c[2], c[3]));
        end
      end
      ibu_pkg::ACT_MIN: if (both) begin
        r = {1'b1, smin(it.a0, it.b0), smin(it.a1, it.b1)};
      end
      ibu_pkg::ACT_MAX: if (both) begin
        r = {1'b1, smax(it.a0, it.b0), smax(it.a1, it.b1)};
      end
      ibu_pkg::ACT_REM: if (both && it.b0 == it.b1 && it.b0 > 0) begin
        mr = it.b0 - 1;
        r.known = 1'b1;
        if (it.a0 >= 0) begin
          r.lo = 0; r.hi = smin(it.a1, mr);
        end else if (it.a1 <= 0) begin
          r.lo = smax(it.a0, -mr); r.hi = 0;
        end else begin
          r.lo = smax(it.a0, -mr); r.hi = smin(it.a1, mr);
        end
      end
      ibu_pkg::ACT_NEG: if (it.lk) begin
        r = {1'b1, -it.a1, -it.a0};
      end
      ibu_pkg::ACT_ABS: if (it.lk) begin
        r.known = 1'b1;
        if (it.a0 >= 0) begin
          r.lo = it.a0; r.hi = it.a1;
        end else if (it.a1 <= 0) begin
          r.lo = -it.a1; r.hi = -it.a0;
        end else begin
          c[0] = (it.a1 < 0) ? -it.a1 : it.a1;
          c[1] = (it.a0 < 0) ? -it.a0 : it.a0;
          r.lo = 0; r.hi = (c[1] < c[0]) ? c[0] : c[1];
        end
      end
      ibu_pkg::ACT_CONV: if (it.lk && it.tb != 0) begin
        if (it.tb >= 32) begin
          r = {1'b1, it.a0, it.a1};
        end else begin
          omax = (32'sd1 <<< (it.tb - 1)) - 1;
          omin = -(32'sd1 <<< (it.tb - 1));
          if (omin <= it.a0 && it.a1 <= omax) r = {1'b1, it.a0, it.a1};
        end
      end
      ibu_pkg::ACT_TRIG: r = {1'b1, -32'sd1, 32'sd1};
      default: r = '0;
    endcase
    if (!r.known) r = '0;
    return r;
  endfunction

  function automatic logic signed [31:0] rand_bound();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $signed($urandom_range(0, 16)) - 8;
      2: return 32'sh8000_0000 + $urandom_range(0, 2);
      3: return 32'sh7fff_ffff - $urandom_range(0, 2);
      4: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $signed($urandom()) >>> $urandom_range(0, 31);
    endcase
  endfunction

  function automatic op_item_t rand_op();
    op_item_t it;
    logic signed [31:0] t;
    it.act = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(11, 15))
                                          : 4'($urandom_range(0, 10));
    it.lk = ($urandom_range(0, 9) != 0);
    it.rk = ($urandom_range(0, 9) != 0);
    it.a0 = rand_bound(); it.a1 = rand_bound();
    it.b0 = rand_bound(); it.b1 = rand_bound();
    // Mostly well-ordered ranges, with some inverted ones left in.
    if ($urandom_range(0, 7) != 0 && it.a0 > it.a1) begin
      t = it.a0; it.a0 = it.a1; it.a1 = t;
    end
    if ($urandom_range(0, 7) != 0 && it.b0 > it.b1) begin
      t = it.b0; it.b0 = it.b1; it.b1 = t;
    end
    if (it.act == ibu_pkg::ACT_REM && $urandom_range(0, 3) != 0) begin
      it.b0 = $urandom_range(1, 100); it.b1 = it.b0;
    end
    if (it.act == ibu_pkg::ACT_DIV && $urandom_range(0, 1) != 0) begin
      it.b0 = $urandom_range(1, 50); it.b1 = it.b0 + $urandom_range(0, 50);
      if ($urandom_range(0, 1) != 0) begin
        t = -it.b1; it.b1 = -it.b0; it.b0 = t;
      end
    end
    it.tb = $urandom_range(0, 127);
    return it;
  endfunction

  function automatic op_item_t mk(logic [3:0] act, logic signed [31:0] a0,
                                  logic signed [31:0] a1, logic signed [31:0] b0,
                                  logic signed [31:0] b1, logic [6:0] tb);
    return '{act, 1'b1, a0, a1, 1'b1, b0, b1, tb};
  endfunction

  task automatic push_op(op_item_t it);
    pending_ops.insert(pending_ops.size(), it);
  endtask

  task automatic drain();
    while (pending_ops.size() != 0 || in_valid || expected_bounds.size() != 0)
      @(posedge clk);
  endtask

  // Driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid && in_ready)
        expected_bounds.insert(expected_bounds.size(),
                               predict_bounds({action, lhs_known, lhs_min, lhs_max,
                                               rhs_known, rhs_min, rhs_max, target_bits}));
      if (pending_ops.size() != 0 && !send_pause &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        op_item_t it;
        it = pending_ops.pop_front();
        in_valid <= 1'b1;
        {action, lhs_known, lhs_min, lhs_max, rhs_known, rhs_min, rhs_max, target_bits} <= it;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bounds.size() == 0) begin
          $error("result beat with no expectation waiting");
          errors++;
        end else begin
          bounds_t e;
          e = expected_bounds.pop_front();
          if (res_known !== e.known) begin
            $error("res_known: expected %0d, got %0d", e.known, res_known); errors++;
          end
          if (res_min !== e.lo) begin
            $error("res_min: expected %0d, got %0d", e.lo, res_min); errors++;
          end
          if (res_max !== e.hi) begin
            $error("res_max: expected %0d, got %0d", e.hi, res_max); errors++;
          end
        end
      end
      if (hold_recv > 0) begin
        hold_recv <= hold_recv - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic signed [31:0] mn, mx;
    op_item_t it;
    mn = 32'sh8000_0000; mx = 32'sh7fff_ffff;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    push_op(mk(ibu_pkg::ACT_ADD, mn, mx, mx, mx, 0));
    push_op(mk(ibu_pkg::ACT_SUB, mn, mx, -1, 1, 0));
    push_op(mk(ibu_pkg::ACT_MUL, mn, mx, -1, 3, 0));
    push_op(mk(ibu_pkg::ACT_DIV, mn, mx, -1, -1, 0));
    push_op(mk(ibu_pkg::ACT_DIV, -7, 9, -1, 2, 0));
    push_op(mk(ibu_pkg::ACT_DIV, -7, 9, 3, 0, 0));
    push_op(mk(ibu_pkg::ACT_DIV, -7, 9, 2, 3, 0));
    push_op(mk(ibu_pkg::ACT_MIN, mn, 5, 3, mx, 0));
    push_op(mk(ibu_pkg::ACT_MAX, mn, 5, 3, mx, 0));
    push_op(mk(ibu_pkg::ACT_REM, -20, 20, 7, 7, 0));
    push_op(mk(ibu_pkg::ACT_REM, 3, 20, 7, 7, 0));
    push_op(mk(ibu_pkg::ACT_REM, -20, -3, 7, 7, 0));
    push_op(mk(ibu_pkg::ACT_REM, -20, 20, 7, 8, 0));
    push_op(mk(ibu_pkg::ACT_NEG, mn, mx, 0, 0, 0));
    push_op(mk(ibu_pkg::ACT_ABS, mn, -1, 0, 0, 0));
    push_op(mk(ibu_pkg::ACT_ABS, -9, 4, 0, 0, 0));
    push_op(mk(ibu_pkg::ACT_CONV, -128, 127, 0, 0, 8));
    push_op(mk(ibu_pkg::ACT_CONV, -129, 127, 0, 0, 8));
    push_op(mk(ibu_pkg::ACT_CONV, -1, 0, 0, 0, 0));
    push_op(mk(ibu_pkg::ACT_CONV, mn, mx, 0, 0, 7'h7f));
    push_op(mk(ibu_pkg::ACT_TRIG, 0, 0, 0, 0, 0));
    push_op(mk(4'd15, 1, 2, 3, 4, 0));
    it = mk(ibu_pkg::ACT_ADD, 1, 2, 3, 4, 0); it.lk = 1'b0; push_op(it);
    it = mk(ibu_pkg::ACT_NEG, 1, 2, 3, 4, 0); it.lk = 1'b0; push_op(it);
    it = mk(ibu_pkg::ACT_MUL, 1, 2, 3, 4, 0); it.rk = 1'b0; push_op(it);
    drain();

    // Long receiver hold-off while items keep coming, so the pipeline backs up.
    hold_recv = 300;
    repeat (150) push_op(rand_op());
    drain();

    send_idle_pct = 18; recv_idle_pct = 67;
    repeat (300) push_op(rand_op());
    drain();
    send_idle_pct = 67; recv_idle_pct = 18;
    repeat (300) push_op(rand_op());
    // Sender pauses until every outstanding result has come back.
    send_pause = 1'b1;
    while (in_valid || expected_bounds.size() != 0) @(posedge clk);
    send_pause = 1'b0;
    drain();
    send_idle_pct = 0; recv_idle_pct = 0;
    repeat (250) push_op(rand_op());
    drain();

    repeat (LATENCY) @(posedge clk);
    if (errors == 0 && expected_bounds.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/ibu_pkg.sv
hdl/ibu_front.sv
hdl/ibu_div_pipe.sv
hdl/ibu_back.sv
hdl/interval_bounds_unit.sv
tb/sv/interval_bounds_unit_tb.sv
